>>> sv/tcum_pkg.sv
`default_nettype none

package tcum_pkg;

    // Stream payload widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 104;

    // Window threshold after reset
    localparam logic [31:0] THRESH_RESET = 32'd1000000;

    // Read address select for the thread tables
    localparam logic [1:0] RD_SEL_ACT   = 2'd0;
    localparam logic [1:0] RD_SEL_SWEEP = 2'd1;
    localparam logic [1:0] RD_SEL_QRY   = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic       load_in;     // capture request fields, update timestamp/expected
        logic       rd_en;       // read thread tables
        logic [1:0] rd_sel;      // which index drives the read
        logic       charge_wr;   // write back charged entry, bump window total
        logic       close_mark;  // latch divisor, restart sweep index
        logic       div_start;   // start one share division
        logic       sweep_wr;    // store share, clear count, advance index
        logic       sum_clear;   // zero the window total
        logic       out_load;    // load result register
    } tcum_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic charge_ok;    // active thread gets charged
        logic over_thresh;  // window total above threshold
        logic div_done;     // quotient ready
        logic sweep_last;   // sweep sits on the last entry
        logic out_free;     // result register can take a new result
    } tcum_sts_t;

endpackage

`default_nettype wire

>>> sv/tcum_div.sv
`default_nettype none

module tcum_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    localparam logic [4:0] LAST_STEP = 5'd31;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  step_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [32:0] shifted;
    logic [32:0] trial;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[31]};
    assign trial   = shifted - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= trial[32] ? shifted[31:0] : trial[31:0];
            quo_reg <= {quo_reg[30:0], ~trial[32]};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> sv/tcum_dp.sv
`default_nettype none

module tcum_dp #(
    parameter int NUM_THREADS = 32,
    parameter int SHARE_SHIFT = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [31:0]                    cfg_wr_data,
    input  wire logic [tcum_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tcum_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire tcum_pkg::tcum_cmd_t            cmd,
    output tcum_pkg::tcum_sts_t                 sts
);

    localparam int IW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam logic [8:0]    NT       = 9'(NUM_THREADS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_THREADS - 1);

    // request fields
    logic [4:0]  in_active;
    logic [4:0]  in_next;
    logic [31:0] in_now;
    logic [4:0]  in_query;

    assign in_active = s_tdata[4:0];
    assign in_next   = s_tdata[9:5];
    assign in_now    = s_tdata[41:10];
    assign in_query  = s_tdata[46:42];

    // thread tables
    logic [63:0] usage_mem [NUM_THREADS];
    logic [31:0] cnt_mem   [NUM_THREADS];
    logic [31:0] shr_mem   [NUM_THREADS];

    logic [NUM_THREADS-1:0] vld_reg;
    logic [31:0] thr_reg;
    logic [31:0] last_ts_reg;
    logic [4:0]  exp_pid_reg;
    logic [31:0] sum_reg;
    logic [31:0] elapsed_reg;
    logic [4:0]  act_reg;
    logic [4:0]  qry_reg;
    logic        charge_ok_reg;
    logic        qry_ok_reg;
    logic        missed_reg;
    logic        closed_reg;
    logic [31:0] divisor_reg;
    logic [IW-1:0] idx_reg;
    logic [63:0] usage_q_reg;
    logic [31:0] cnt_q_reg;
    logic [31:0] shr_q_reg;
    logic        rd_vld_reg;
    logic        m_tvalid_reg;
    logic [tcum_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [IW-1:0] act_addr;
    logic [IW-1:0] qry_addr;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [63:0]   usage_rd;
    logic [31:0]   cnt_rd;
    logic [31:0]   shr_rd;
    logic [31:0]   sum_shr;
    logic [31:0]   quotient;
    logic          div_done;

    assign act_addr = IW'({3'b000, act_reg});
    assign qry_addr = IW'({3'b000, qry_reg});
    assign wr_addr  = cmd.charge_wr ? act_addr : idx_reg;

    always_comb begin
        unique case (cmd.rd_sel)
            tcum_pkg::RD_SEL_ACT:   rd_addr = act_addr;
            tcum_pkg::RD_SEL_SWEEP: rd_addr = idx_reg;
            tcum_pkg::RD_SEL_QRY:   rd_addr = qry_addr;
            default:                rd_addr = idx_reg;
        endcase
    end

    // entries never written read as zero
    assign usage_rd = rd_vld_reg ? usage_q_reg : 64'd0;
    assign cnt_rd   = rd_vld_reg ? cnt_q_reg   : 32'd0;
    assign shr_rd   = rd_vld_reg ? shr_q_reg   : 32'd0;

    assign sum_shr  = sum_reg >> SHARE_SHIFT;

    // table reads, registered
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            usage_q_reg <= usage_mem[rd_addr];
            cnt_q_reg   <= cnt_mem[rd_addr];
            shr_q_reg   <= shr_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    // table writes
    always_ff @(posedge aclk) begin
        if (cmd.charge_wr) begin
            usage_mem[wr_addr] <= usage_rd + {32'd0, elapsed_reg};
        end
        if (cmd.charge_wr || cmd.sweep_wr) begin
            cnt_mem[wr_addr] <= cmd.charge_wr ? (cnt_rd + elapsed_reg) : 32'd0;
            shr_mem[wr_addr] <= cmd.charge_wr ? (shr_rd + (elapsed_reg >> SHARE_SHIFT))
                                              : quotient;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            thr_reg      <= tcum_pkg::THRESH_RESET;
            last_ts_reg  <= '0;
            exp_pid_reg  <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (cmd.load_in) begin
                last_ts_reg <= in_now;
                if (!s_tuser) begin
                    exp_pid_reg <= in_next;
                end
            end
            if (cmd.charge_wr) begin
                vld_reg[act_addr] <= 1'b1;
                sum_reg           <= sum_reg + elapsed_reg;
            end else if (cmd.sum_clear) begin
                sum_reg <= '0;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // per-request working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            elapsed_reg   <= in_now - last_ts_reg;
            act_reg       <= in_active;
            qry_reg       <= in_query;
            missed_reg    <= (in_active != exp_pid_reg);
            charge_ok_reg <= (in_active == exp_pid_reg) && (in_active != 5'd0)
                             && ({4'd0, in_active} < NT);
            qry_ok_reg    <= ({4'd0, in_query} < NT);
            closed_reg    <= 1'b0;
        end
        if (cmd.close_mark) begin
            closed_reg  <= 1'b1;
            divisor_reg <= (sum_shr == 32'd0) ? 32'd1 : sum_shr;
            idx_reg     <= '0;
        end else if (cmd.sweep_wr) begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {6'd0, missed_reg, closed_reg,
                            qry_ok_reg ? shr_rd : 32'd0,
                            qry_ok_reg ? usage_rd : 64'd0};
        end
    end

    tcum_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cnt_rd),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sts.charge_ok   = charge_ok_reg;
    assign sts.over_thresh = (sum_reg > thr_reg);
    assign sts.div_done    = div_done;
    assign sts.sweep_last  = (idx_reg == LAST_IDX);
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> sv/tcum_ctrl.sv
`default_nettype none

module tcum_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output tcum_pkg::tcum_cmd_t      cmd,
    input  wire tcum_pkg::tcum_sts_t sts
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDA  = 4'd1;
    localparam logic [3:0] ST_CHG  = 4'd2;
    localparam logic [3:0] ST_CMP  = 4'd3;
    localparam logic [3:0] ST_SRD  = 4'd4;
    localparam logic [3:0] ST_SDS  = 4'd5;
    localparam logic [3:0] ST_SDW  = 4'd6;
    localparam logic [3:0] ST_RDQ  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = tcum_pkg::RD_SEL_ACT;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_RDA;
                end
            end
            ST_RDA: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHG;
            end
            ST_CHG: begin
                if (sts.charge_ok) begin
                    cmd.charge_wr = 1'b1;
                    state_next    = ST_CMP;
                end else begin
                    state_next = ST_RDQ;
                end
            end
            ST_CMP: begin
                if (sts.over_thresh) begin
                    cmd.close_mark = 1'b1;
                    state_next     = ST_SRD;
                end else begin
                    state_next = ST_RDQ;
                end
            end
            ST_SRD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tcum_pkg::RD_SEL_SWEEP;
                state_next = ST_SDS;
            end
            ST_SDS: begin
                cmd.div_start = 1'b1;
                state_next    = ST_SDW;
            end
            ST_SDW: begin
                if (sts.div_done) begin
                    cmd.sweep_wr = 1'b1;
                    if (sts.sweep_last) begin
                        cmd.sum_clear = 1'b1;
                        state_next    = ST_RDQ;
                    end else begin
                        state_next = ST_SRD;
                    end
                end
            end
            ST_RDQ: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tcum_pkg::RD_SEL_QRY;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/thread_cpu_usage_monitor.sv
// A request is accepted in IDLE and passes RDA, CHG, CMP when a thread is charged, RDQ and OUT,
// where the result enters the output register; when the window closes, a sweep after CMP runs
// every thread's window count through one shared 32-step divider.
// One request at a time; OUT waits while the output register holds an unread result; the next
// is taken the cycle after the result enters the output register. Reset (aresetn low, synchronous)
// clears tables via valid bits, the sequencer state and window bookkeeping; threshold 1000000.
`default_nettype none

module thread_cpu_usage_monitor #(
    parameter int NUM_THREADS = 32,
    parameter int SHARE_SHIFT = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // window threshold register
    input  wire logic                           cfg_wr_en,
    input  wire logic [31:0]                    cfg_wr_data,
    // scheduler event requests
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cur_thread[4:0], new_thread[9:5], now_ticks[41:10], query_pid[46:42], zero [47]
    input  wire logic [tcum_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0]: 0 context switch, 1 periodic tick
    input  wire logic                           s_tuser,
    // per-event report
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // query_usage[63:0], query_share[95:64], window_closed[96], missed_switch[97],
    // zero [103:98]
    output logic [tcum_pkg::M_TDATA_W-1:0]      m_tdata
);

    tcum_pkg::tcum_cmd_t cmd;
    tcum_pkg::tcum_sts_t sts;

    // Sequencer: accept, read the active thread's entry, charge it if eligible and then check the window
    // total, sweep all threads on close, then read the queried thread and report.
    tcum_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Thread tables, window bookkeeping, share divider and the result register.
    tcum_dp #(
        .NUM_THREADS (NUM_THREADS),
        .SHARE_SHIFT (SHARE_SHIFT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire
